>>> rtl/core/sd_card_spi_slave_macros.svh
// Assertion macros used by the SD card SPI slave RTL.
`ifndef SD_CARD_SPI_SLAVE_MACROS_SVH
`define SD_CARD_SPI_SLAVE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and switched off during rst.
`define SDSPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, sampled on clk and switched off during rst.
`define SDSPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SDSPI_ASSERT_IMP(lbl, ante, cons)
`define SDSPI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/sdspi_pkg.sv
// Types, constants and tables of the SD card SPI slave.
`default_nettype none
package sdspi_pkg;

  localparam int STORE_BYTES  = 65536;
  localparam int STORE_AW     = $clog2(STORE_BYTES);
  localparam int MAX_BLOCK    = 512;
  localparam int BUFFER_DEPTH = 520;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = 10;
  localparam int ARG_W        = 32;
  localparam int OFF_W        = ARG_W + CNT_W;
  localparam int DIV_CNT_W    = $clog2(ARG_W + 1);

  localparam logic CFG_CARD_PRESENT    = 1'b0;
  localparam logic CFG_BYTE_ADDRESSING = 1'b1;

  localparam logic [7:0] TOKEN_START = 8'hFE;

  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_OP    = 6'd1;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
  localparam logic [5:0] CMD_SEND_CID   = 6'd10;
  localparam logic [5:0] CMD_STOP       = 6'd12;
  localparam logic [5:0] CMD_STATUS     = 6'd13;
  localparam logic [5:0] CMD_SET_BLEN   = 6'd16;
  localparam logic [5:0] CMD_READ_ONE   = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI = 6'd18;
  localparam logic [5:0] CMD_WRITE_ONE  = 6'd24;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_APP_CMD    = 6'd55;
  localparam logic [5:0] CMD_READ_OCR   = 6'd58;
  localparam logic [5:0] CMD_CRC_ON     = 6'd59;

  localparam logic [7:0] CID_BYTES [16] = '{
    8'h4D, 8'h4D, 8'h44, 8'h4D, 8'h43, 8'h41, 8'h52, 8'h44,
    8'h10, 8'h12, 8'h34, 8'h56, 8'h78, 8'h01, 8'h59, 8'h00
  };

  typedef enum logic [18:0] {
    ST_IDLE    = 19'h00001,
    ST_CLEAR   = 19'h00002,
    ST_BYTE    = 19'h00004,
    ST_GIVE    = 19'h00008,
    ST_GIVE_RD = 19'h00010,
    ST_OUT     = 19'h00020,
    ST_CONST   = 19'h00040,
    ST_DIV     = 19'h00080,
    ST_MUL     = 19'h00100,
    ST_CHK     = 19'h00200,
    ST_SRD     = 19'h00400,
    ST_SWR     = 19'h00800,
    ST_BRD     = 19'h01000,
    ST_BWR     = 19'h02000,
    ST_CRD     = 19'h04000,
    ST_CUP     = 19'h08000,
    ST_CWH     = 19'h10000,
    ST_CWL     = 19'h20000,
    ST_FIN     = 19'h40000
  } state_t;

  typedef enum logic [8:0] {
    M_IDLE   = 9'h001,
    M_WAITFE = 9'h002,
    M_WDATA  = 9'h004,
    M_MULTI  = 9'h008,
    M_INA    = 9'h010,
    M_READY  = 9'h020,
    M_STBY   = 9'h040,
    M_TRAN   = 9'h080,
    M_DATA   = 9'h100
  } mode_t;

  typedef enum logic [2:0] {
    J_SIMPLE, J_CID, J_READ, J_ARG, J_PKT, J_WRITE
  } job_t;

  typedef enum logic [3:0] {
    R_R1_01, R_R1_00, R_R1_FF, R_IF_COND, R_CID, R_TOKEN, R_OCR,
    R_PKT, R_WR_OK, R_WR_BAD
  } rsel_t;

  typedef struct packed {
    logic             start;
    logic [ARG_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ARG_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [4:0] reply_len(input rsel_t sel);
    case (sel)
      R_IF_COND: return 5'd5;
      R_CID:     return 5'd19;
      R_TOKEN:   return 5'd3;
      R_OCR:     return 5'd5;
      R_WR_OK:   return 5'd2;
      R_WR_BAD:  return 5'd2;
      default:   return 5'd1;
    endcase
  endfunction

  function automatic logic [7:0] reply_byte(input rsel_t sel, input logic [4:0] idx,
                                            input logic byte_addr);
    logic [4:0] cid_idx;
    cid_idx = idx - 5'd3;
    case (sel)
      R_R1_01:   return 8'h01;
      R_R1_00:   return 8'h00;
      R_R1_FF:   return 8'hFF;
      R_IF_COND: begin
        case (idx)
          5'd0:    return 8'h01;
          5'd3:    return 8'h01;
          5'd4:    return 8'hAA;
          default: return 8'h00;
        endcase
      end
      R_CID: begin
        case (idx)
          5'd0:    return 8'h00;
          5'd1:    return 8'hFF;
          5'd2:    return TOKEN_START;
          default: return CID_BYTES[cid_idx[3:0]];
        endcase
      end
      R_TOKEN: begin
        case (idx)
          5'd0:    return 8'h00;
          5'd1:    return 8'hFF;
          default: return TOKEN_START;
        endcase
      end
      R_OCR:     return (idx == 5'd1 && !byte_addr) ? 8'h40 : 8'h00;
      R_PKT:     return TOKEN_START;
      R_WR_OK:   return (idx == 5'd0) ? 8'h05 : 8'h01;
      R_WR_BAD:  return (idx == 5'd0) ? 8'h0D : 8'h01;
      default:   return 8'hFF;
    endcase
  endfunction

  // CRC16 with polynomial 0x1021, one byte folded in msb first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sdspi_ram.sv
// Single-port RAM with registered read data.
`default_nettype none
module sdspi_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we && (32'(addr) < DEPTH)) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/sdspi_divider.sv
// Restoring divider that yields one quotient bit a cycle.
`default_nettype none
module sdspi_divider (
  input  logic               clk,
  input  logic               rst,
  input  sdspi_pkg::div_req_t req,
  output sdspi_pkg::div_rsp_t rsp
);

  localparam int AW = sdspi_pkg::ARG_W;
  localparam int DW = sdspi_pkg::CNT_W;
  localparam int CW = sdspi_pkg::DIV_CNT_W;

  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW-1:0] rem;
  logic [AW-1:0] quo;
  logic [DW-1:0] divisor;
  logic [DW:0]   trial;

  assign trial = {rem, quo[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CW'(AW);
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= DW'(trial - {1'b0, divisor});
          quo <= {quo[AW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[AW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> rtl/core/sd_card_spi_slave.sv
// Top level of the SD card SPI-mode slave: byte sequencer, reply buffer and store.
//
//   channel | direction | handshake            | payload
//   in      | to card   | in_valid / in_stall   | kind, host_byte
//   out     | from card | out_valid / out_stall | card_byte
//   cfg     | to card   | cfg_we                | cfg_index, cfg_data
//
// A sent byte passes through ST_BYTE; a read request through ST_GIVE, then ST_GIVE_RD
// when it takes a byte from the reply buffer, then ST_OUT; a command that builds a data
// packet runs the copy loop (ST_SRD, ST_SWR) and the CRC loop (ST_CRD, ST_CUP) per block byte.
// After reset the store is cleared, one byte a cycle, across all 65536 bytes.
// Items are taken one at a time; a read waits in place while the result
// register is full and stalled.
`default_nettype none
`include "sd_card_spi_slave_macros.svh"
module sd_card_spi_slave (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] host_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] card_byte,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  localparam int SAW = sdspi_pkg::STORE_AW;
  localparam int BAW = sdspi_pkg::BUF_AW;
  localparam int CW  = sdspi_pkg::CNT_W;
  localparam int OW  = sdspi_pkg::OFF_W;
  localparam int AW  = sdspi_pkg::ARG_W;

  sdspi_pkg::state_t state;
  sdspi_pkg::mode_t  mode;
  sdspi_pkg::mode_t  fmode;
  sdspi_pkg::job_t   job;
  sdspi_pkg::rsel_t  rsel;

  logic [7:0]    win [6];
  logic [CW-1:0] pending, sp, rp, bl, fcount;
  logic [AW-1:0] next_block, q;
  logic          app_prefix, present, byte_addr;
  logic [7:0]    last_out, res;
  logic [4:0]    cidx;
  logic [OW-1:0] off;
  logic [CW-1:0] dst, ci, cstart, crclen;
  logic [15:0]   crc;
  logic [SAW-1:0] clr;
  logic          div_go;

  logic           buf_we;
  logic [BAW-1:0] buf_addr;
  logic [7:0]     buf_wdata, buf_rdata;
  logic           st_we;
  logic [SAW-1:0] st_addr;
  logic [7:0]     st_wdata, st_rdata;

  sdspi_pkg::div_req_t div_req;
  sdspi_pkg::div_rsp_t div_rsp;

  // Command decode on the shifted window.
  logic             framed, may_decode, known, use_arg;
  logic [5:0]       op;
  logic [15:0]      len16;
  logic [CW-1:0]    len_clamped;
  sdspi_pkg::rsel_t dc_rsel;
  sdspi_pkg::job_t  dc_job;
  logic [CW-1:0]    dc_count;
  sdspi_pkg::mode_t dc_mode;
  logic             in_store;
  logic [CW-1:0]    rp_inc;

  assign framed = (win[0][7:6] == 2'b01) && win[5][0];
  assign op     = win[0][5:0];
  assign len16  = {win[3], win[4]};
  assign len_clamped = (len16 == 16'd0) ? CW'(1) :
                       (len16 > 16'(sdspi_pkg::MAX_BLOCK)) ? CW'(sdspi_pkg::MAX_BLOCK) :
                       len16[CW-1:0];
  assign may_decode = (mode == sdspi_pkg::M_IDLE) || (mode == sdspi_pkg::M_MULTI) ||
                      (win[0][6:4] == 3'b100) || (pending == '0);
  assign in_store = ({1'b0, off} + (OW+1)'(bl)) <= (OW+1)'(sdspi_pkg::STORE_BYTES);
  assign rp_inc   = rp + 1'b1;

  always_comb begin
    known    = 1'b1;
    use_arg  = 1'b0;
    dc_rsel  = sdspi_pkg::R_R1_00;
    dc_job   = sdspi_pkg::J_SIMPLE;
    dc_count = CW'(1);
    dc_mode  = sdspi_pkg::M_IDLE;
    case (op)
      sdspi_pkg::CMD_GO_IDLE: dc_rsel = sdspi_pkg::R_R1_01;
      sdspi_pkg::CMD_SEND_OP: dc_mode = sdspi_pkg::M_READY;
      sdspi_pkg::CMD_IF_COND: begin
        dc_rsel  = sdspi_pkg::R_IF_COND;
        dc_count = CW'(5);
      end
      sdspi_pkg::CMD_SEND_CSD, sdspi_pkg::CMD_STATUS, sdspi_pkg::CMD_CRC_ON: begin
        dc_mode = sdspi_pkg::M_STBY;
      end
      sdspi_pkg::CMD_SEND_CID: begin
        dc_rsel  = sdspi_pkg::R_CID;
        dc_job   = sdspi_pkg::J_CID;
        dc_count = CW'(21);
        dc_mode  = sdspi_pkg::M_STBY;
      end
      sdspi_pkg::CMD_STOP:     dc_mode = sdspi_pkg::M_TRAN;
      sdspi_pkg::CMD_SET_BLEN: dc_mode = sdspi_pkg::M_TRAN;
      sdspi_pkg::CMD_READ_ONE: begin
        dc_rsel  = sdspi_pkg::R_TOKEN;
        dc_job   = sdspi_pkg::J_READ;
        dc_count = bl + CW'(5);
        dc_mode  = sdspi_pkg::M_DATA;
        use_arg  = 1'b1;
      end
      sdspi_pkg::CMD_READ_MULTI: begin
        dc_job  = sdspi_pkg::J_ARG;
        dc_mode = sdspi_pkg::M_MULTI;
        use_arg = 1'b1;
      end
      sdspi_pkg::CMD_WRITE_ONE: begin
        dc_job  = sdspi_pkg::J_ARG;
        dc_mode = sdspi_pkg::M_WAITFE;
        use_arg = 1'b1;
      end
      sdspi_pkg::CMD_APP_OP: begin
        if (app_prefix) begin
          dc_mode = sdspi_pkg::M_READY;
        end else begin
          dc_rsel = sdspi_pkg::R_R1_FF;
          dc_mode = sdspi_pkg::M_INA;
        end
      end
      sdspi_pkg::CMD_APP_CMD: dc_rsel = sdspi_pkg::R_R1_01;
      sdspi_pkg::CMD_READ_OCR: begin
        dc_rsel  = sdspi_pkg::R_OCR;
        dc_count = CW'(5);
        dc_mode  = sdspi_pkg::M_DATA;
      end
      default: known = 1'b0;
    endcase
  end

  // Memory port selection by sequencer state.
  always_comb begin
    buf_we    = 1'b0;
    buf_addr  = '0;
    buf_wdata = '0;
    st_we     = 1'b0;
    st_addr   = '0;
    st_wdata  = '0;
    case (state)
      sdspi_pkg::ST_BYTE: begin
        buf_we    = (mode == sdspi_pkg::M_WDATA);
        buf_addr  = rp;
        buf_wdata = win[5];
      end
      sdspi_pkg::ST_GIVE: buf_addr = sp - 1'b1;
      sdspi_pkg::ST_CONST: begin
        buf_we    = 1'b1;
        buf_addr  = BAW'(cidx);
        buf_wdata = sdspi_pkg::reply_byte(rsel, cidx, byte_addr);
      end
      sdspi_pkg::ST_SRD: st_addr = off[SAW-1:0] + SAW'(ci);
      sdspi_pkg::ST_SWR: begin
        buf_we    = 1'b1;
        buf_addr  = dst + ci;
        buf_wdata = st_rdata;
      end
      sdspi_pkg::ST_BRD: buf_addr = ci;
      sdspi_pkg::ST_BWR: begin
        st_we    = 1'b1;
        st_addr  = off[SAW-1:0] + SAW'(ci);
        st_wdata = buf_rdata;
      end
      sdspi_pkg::ST_CRD: buf_addr = cstart + ci;
      sdspi_pkg::ST_CWH: begin
        buf_we    = 1'b1;
        buf_addr  = cstart + crclen;
        buf_wdata = crc[15:8];
      end
      sdspi_pkg::ST_CWL: begin
        buf_we    = 1'b1;
        buf_addr  = cstart + crclen + 1'b1;
        buf_wdata = crc[7:0];
      end
      sdspi_pkg::ST_CLEAR: begin
        st_we   = 1'b1;
        st_addr = clr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sdspi_pkg::ST_CLEAR;
      mode       <= sdspi_pkg::M_IDLE;
      for (int i = 0; i < 6; i++) win[i] <= 8'h00;
      pending    <= '0;
      sp         <= '0;
      rp         <= '0;
      bl         <= CW'(sdspi_pkg::MAX_BLOCK);
      next_block <= '0;
      app_prefix <= 1'b0;
      last_out   <= 8'h00;
      present    <= 1'b1;
      byte_addr  <= 1'b0;
      out_valid  <= 1'b0;
      div_go     <= 1'b0;
      clr        <= '0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == sdspi_pkg::CFG_CARD_PRESENT) present <= cfg_data;
        else byte_addr <= cfg_data;
      end
      case (state)
        sdspi_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SAW'(sdspi_pkg::STORE_BYTES - 1)) state <= sdspi_pkg::ST_IDLE;
        end
        sdspi_pkg::ST_IDLE: begin
          if (in_valid) begin
            if (kind) begin
              state <= sdspi_pkg::ST_GIVE;
            end else if (present) begin
              for (int i = 0; i < 5; i++) win[i] <= win[i+1];
              win[5] <= host_byte;
              state  <= sdspi_pkg::ST_BYTE;
            end
          end
        end
        sdspi_pkg::ST_BYTE: begin
          state <= sdspi_pkg::ST_IDLE;
          case (mode)
            sdspi_pkg::M_WAITFE: begin
              if (win[5] == sdspi_pkg::TOKEN_START) begin
                mode     <= sdspi_pkg::M_WDATA;
                last_out <= 8'hFF;
                rp       <= '0;
              end
            end
            sdspi_pkg::M_WDATA: begin
              rp <= rp_inc;
              if (rp_inc == bl + CW'(2)) begin
                q      <= next_block;
                job    <= sdspi_pkg::J_WRITE;
                fcount <= CW'(2);
                fmode  <= sdspi_pkg::M_IDLE;
                state  <= sdspi_pkg::ST_MUL;
              end
            end
            default: begin
              if (may_decode && framed) begin
                last_out   <= 8'hFF;
                app_prefix <= (op == sdspi_pkg::CMD_APP_CMD);
              end
              if (may_decode && framed && known) begin
                for (int i = 0; i < 6; i++) win[i] <= 8'hFF;
                rsel   <= dc_rsel;
                job    <= dc_job;
                fcount <= dc_count;
                fmode  <= dc_mode;
                cidx   <= '0;
                dst    <= CW'(3);
                q      <= {win[1], win[2], win[3], win[4]};
                if (op == sdspi_pkg::CMD_SET_BLEN) bl <= len_clamped;
                if (op == sdspi_pkg::CMD_READ_MULTI) last_out <= 8'h00;
                if (use_arg && byte_addr) begin
                  div_go <= 1'b1;
                  state  <= sdspi_pkg::ST_DIV;
                end else begin
                  state <= sdspi_pkg::ST_CONST;
                end
              end else if (mode == sdspi_pkg::M_MULTI && pending == '0) begin
                // Drained in multi-block read: the next packet is built.
                rsel       <= sdspi_pkg::R_PKT;
                job        <= sdspi_pkg::J_PKT;
                q          <= next_block;
                next_block <= next_block + 1'b1;
                dst        <= CW'(1);
                fcount     <= bl + CW'(3);
                fmode      <= sdspi_pkg::M_MULTI;
                cidx       <= '0;
                state      <= sdspi_pkg::ST_CONST;
              end
            end
          endcase
        end
        sdspi_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            q     <= div_rsp.quotient;
            state <= sdspi_pkg::ST_CONST;
          end
        end
        sdspi_pkg::ST_CONST: begin
          cidx <= cidx + 1'b1;
          if (cidx == sdspi_pkg::reply_len(rsel) - 1'b1) begin
            case (job)
              sdspi_pkg::J_CID: begin
                cstart <= CW'(3);
                crclen <= CW'(16);
                crc    <= '0;
                ci     <= '0;
                state  <= sdspi_pkg::ST_CRD;
              end
              sdspi_pkg::J_READ, sdspi_pkg::J_PKT: state <= sdspi_pkg::ST_MUL;
              default: state <= sdspi_pkg::ST_FIN;
            endcase
          end
        end
        sdspi_pkg::ST_MUL: begin
          off   <= OW'(q) * OW'(bl);
          state <= sdspi_pkg::ST_CHK;
        end
        sdspi_pkg::ST_CHK: begin
          ci <= '0;
          if (job == sdspi_pkg::J_WRITE) begin
            if (in_store) begin
              state <= sdspi_pkg::ST_BRD;
            end else begin
              rsel  <= sdspi_pkg::R_WR_BAD;
              cidx  <= '0;
              state <= sdspi_pkg::ST_CONST;
            end
          end else if (in_store) begin
            state <= sdspi_pkg::ST_SRD;
          end else begin
            // Outside the store the buffer keeps its contents; CRC covers them.
            cstart <= dst;
            crclen <= bl;
            crc    <= '0;
            state  <= sdspi_pkg::ST_CRD;
          end
        end
        sdspi_pkg::ST_SRD: state <= sdspi_pkg::ST_SWR;
        sdspi_pkg::ST_SWR: begin
          if (ci == bl - 1'b1) begin
            cstart <= dst;
            crclen <= bl;
            crc    <= '0;
            ci     <= '0;
            state  <= sdspi_pkg::ST_CRD;
          end else begin
            ci    <= ci + 1'b1;
            state <= sdspi_pkg::ST_SRD;
          end
        end
        sdspi_pkg::ST_BRD: state <= sdspi_pkg::ST_BWR;
        sdspi_pkg::ST_BWR: begin
          if (ci == bl - 1'b1) begin
            rsel  <= sdspi_pkg::R_WR_OK;
            cidx  <= '0;
            state <= sdspi_pkg::ST_CONST;
          end else begin
            ci    <= ci + 1'b1;
            state <= sdspi_pkg::ST_BRD;
          end
        end
        sdspi_pkg::ST_CRD: state <= sdspi_pkg::ST_CUP;
        sdspi_pkg::ST_CUP: begin
          crc <= sdspi_pkg::crc_byte(crc, buf_rdata);
          if (ci == crclen - 1'b1) begin
            state <= sdspi_pkg::ST_CWH;
          end else begin
            ci    <= ci + 1'b1;
            state <= sdspi_pkg::ST_CRD;
          end
        end
        sdspi_pkg::ST_CWH: state <= sdspi_pkg::ST_CWL;
        sdspi_pkg::ST_CWL: state <= sdspi_pkg::ST_FIN;
        sdspi_pkg::ST_FIN: begin
          sp      <= '0;
          pending <= fcount;
          mode    <= fmode;
          if (job == sdspi_pkg::J_ARG) next_block <= q;
          state   <= sdspi_pkg::ST_IDLE;
        end
        sdspi_pkg::ST_GIVE: begin
          state <= sdspi_pkg::ST_OUT;
          if (!present) begin
            res <= 8'hFF;
          end else if (sp == '0) begin
            // The delay byte repeats whatever went out last.
            sp  <= CW'(1);
            res <= last_out;
          end else if (pending != '0) begin
            state <= sdspi_pkg::ST_GIVE_RD;
          end else begin
            last_out <= 8'hFF;
            res      <= 8'hFF;
          end
        end
        sdspi_pkg::ST_GIVE_RD: begin
          last_out <= buf_rdata;
          res      <= buf_rdata;
          sp       <= sp + 1'b1;
          pending  <= pending - 1'b1;
          state    <= sdspi_pkg::ST_OUT;
        end
        sdspi_pkg::ST_OUT: begin
          if (!out_valid || !out_stall) begin
            card_byte <= res;
            out_valid <= 1'b1;
            state     <= sdspi_pkg::ST_IDLE;
          end
        end
        default: state <= sdspi_pkg::ST_IDLE;
      endcase
    end
  end

  assign in_stall = (state != sdspi_pkg::ST_IDLE);

  assign div_req.start    = div_go;
  assign div_req.dividend = q;
  assign div_req.divisor  = bl;

  sdspi_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sdspi_ram #(
    .DEPTH (sdspi_pkg::BUFFER_DEPTH),
    .WIDTH (8)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .addr  (buf_addr),
    .wdata (buf_wdata),
    .rdata (buf_rdata)
  );

  sdspi_ram #(
    .DEPTH (sdspi_pkg::STORE_BYTES),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  `SDSPI_ASSERT_NXT(a_out_load, state == sdspi_pkg::ST_OUT && !(out_valid && out_stall), out_valid)
  `SDSPI_ASSERT_IMP(a_pending_range, 1'b1, pending <= CW'(sdspi_pkg::BUFFER_DEPTH))
  `SDSPI_ASSERT_IMP(a_wdata_ptr, mode == sdspi_pkg::M_WDATA && state == sdspi_pkg::ST_IDLE, rp <= bl + 1'b1)

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the SD card SPI-mode slave, with its own byte-level card model.
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 3000;
  localparam int ITEMS = 1250;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, kind = 1'b0;
  logic [7:0] host_byte = 8'h00;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0, cfg_index = 1'b0, cfg_data = 1'b0;
  wire in_stall, out_valid;
  wire [7:0] card_byte;

  sd_card_spi_slave uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .host_byte(host_byte), .out_valid(out_valid), .out_stall(out_stall),
    .card_byte(card_byte), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Card model state.
  logic        card_on = 1'b1, byte_addr = 1'b0;
  sdspi_pkg::mode_t mode_now = sdspi_pkg::M_IDLE;
  logic [7:0]  cmd_win [6];
  logic [7:0]  reply_buf [sdspi_pkg::BUFFER_DEPTH];
  logic [7:0]  store_img [sdspi_pkg::STORE_BYTES];
  int unsigned pend = 0, send_ptr = 0, recv_ptr = 0, blen = sdspi_pkg::MAX_BLOCK;
  logic [31:0] next_blk = 0;
  logic        app_seen = 1'b0;
  logic [7:0]  last_byte = 8'h00;

  logic [7:0]  card_bytes_due [$];
  int          errors = 0;
  int          cycle = 0;
  int          hold_until = 0;
  int          sent_items = 0;
  bit          calm = 1'b0;

  initial begin
    foreach (cmd_win[i]) cmd_win[i] = 8'h00;
    foreach (reply_buf[i]) reply_buf[i] = 8'h00;
    foreach (store_img[i]) store_img[i] = 8'h00;
  end

  function automatic void buf_set(int unsigned i, logic [7:0] v);
    if (i < sdspi_pkg::BUFFER_DEPTH) reply_buf[i] = v;
  endfunction

  function automatic logic [7:0] buf_at(int unsigned i);
    return (i < sdspi_pkg::BUFFER_DEPTH) ? reply_buf[i] : 8'h00;
  endfunction

  function automatic void begin_reply(int unsigned cnt, sdspi_pkg::mode_t m);
    send_ptr = 0;
    pend = cnt & 10'h3FF;
    mode_now = m;
  endfunction

  function automatic void append_crc16(int unsigned start, int unsigned len);
    logic [15:0] crc;
    crc = 16'h0000;
    for (int unsigned i = 0; i < len; i++) begin
      crc ^= {buf_at(start + i), 8'h00};
      for (int b = 0; b < 8; b++) crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
    end
    buf_set(start + len, crc[15:8]);
    buf_set(start + len + 1, crc[7:0]);
  endfunction

  function automatic bit block_fits(logic [31:0] blk, output logic [63:0] off);
    off = {32'd0, blk} * blen;
    return off + blen <= sdspi_pkg::STORE_BYTES;
  endfunction

  function automatic void load_block(logic [31:0] blk, int unsigned dst);
    logic [63:0] off;
    if (!block_fits(blk, off)) return;
    for (int unsigned i = 0; i < blen; i++) buf_set(dst + i, store_img[off + i]);
  endfunction

  function automatic bit save_block(logic [31:0] blk);
    logic [63:0] off;
    if (!block_fits(blk, off)) return 1'b0;
    for (int unsigned i = 0; i < blen; i++) store_img[off + i] = buf_at(i);
    return 1'b1;
  endfunction

  function automatic logic [31:0] arg_block();
    logic [31:0] a;
    a = {cmd_win[1], cmd_win[2], cmd_win[3], cmd_win[4]};
    if (byte_addr) a = a / blen;
    return a;
  endfunction

  function automatic void decode_window();
    logic [5:0]  op;
    logic [15:0] len;
    bit          known;
    if ((cmd_win[0] & 8'hC0) != 8'h40 || !cmd_win[5][0]) return;
    last_byte = 8'hFF;
    op = cmd_win[0][5:0];
    known = 1'b1;
    case (op)
      sdspi_pkg::CMD_GO_IDLE: begin
        buf_set(0, 8'h01); begin_reply(1, sdspi_pkg::M_IDLE);
      end
      sdspi_pkg::CMD_SEND_OP: begin
        buf_set(0, 8'h00); begin_reply(1, sdspi_pkg::M_READY);
      end
      sdspi_pkg::CMD_IF_COND: begin
        buf_set(0, 8'h01); buf_set(1, 8'h00); buf_set(2, 8'h00);
        buf_set(3, 8'h01); buf_set(4, 8'hAA);
        begin_reply(5, sdspi_pkg::M_IDLE);
      end
      sdspi_pkg::CMD_SEND_CSD, sdspi_pkg::CMD_STATUS, sdspi_pkg::CMD_CRC_ON: begin
        buf_set(0, 8'h00); begin_reply(1, sdspi_pkg::M_STBY);
      end
      sdspi_pkg::CMD_SEND_CID: begin
        buf_set(0, 8'h00); buf_set(1, 8'hFF); buf_set(2, sdspi_pkg::TOKEN_START);
        for (int i = 0; i < 16; i++) buf_set(3 + i, sdspi_pkg::CID_BYTES[i]);
        append_crc16(3, 16);
        begin_reply(21, sdspi_pkg::M_STBY);
      end
      sdspi_pkg::CMD_STOP: begin
        buf_set(0, 8'h00); begin_reply(1, sdspi_pkg::M_TRAN);
      end
      sdspi_pkg::CMD_SET_BLEN: begin
        len = {cmd_win[3], cmd_win[4]};
        if (len < 1) len = 1;
        if (len > sdspi_pkg::MAX_BLOCK) len = sdspi_pkg::MAX_BLOCK;
        blen = len;
        buf_set(0, 8'h00);
        begin_reply(1, sdspi_pkg::M_TRAN);
      end
      sdspi_pkg::CMD_READ_ONE: begin
        buf_set(0, 8'h00); buf_set(1, 8'hFF); buf_set(2, sdspi_pkg::TOKEN_START);
        load_block(arg_block(), 3);
        append_crc16(3, blen);
        begin_reply(blen + 5, sdspi_pkg::M_DATA);
      end
      sdspi_pkg::CMD_READ_MULTI: begin
        buf_set(0, 8'h00);
        last_byte = 8'h00;
        next_blk = arg_block();
        begin_reply(1, sdspi_pkg::M_MULTI);
      end
      sdspi_pkg::CMD_WRITE_ONE: begin
        buf_set(0, 8'h00);
        next_blk = arg_block();
        begin_reply(1, sdspi_pkg::M_WAITFE);
      end
      sdspi_pkg::CMD_APP_OP: begin
        if (app_seen) begin buf_set(0, 8'h00); begin_reply(1, sdspi_pkg::M_READY); end
        else begin buf_set(0, 8'hFF); begin_reply(1, sdspi_pkg::M_INA); end
      end
      sdspi_pkg::CMD_APP_CMD: begin
        buf_set(0, 8'h01); begin_reply(1, sdspi_pkg::M_IDLE);
      end
      sdspi_pkg::CMD_READ_OCR: begin
        buf_set(0, 8'h00); buf_set(1, byte_addr ? 8'h00 : 8'h40);
        buf_set(2, 8'h00); buf_set(3, 8'h00); buf_set(4, 8'h00);
        begin_reply(5, sdspi_pkg::M_DATA);
      end
      default: known = 1'b0;
    endcase
    app_seen = (op == sdspi_pkg::CMD_APP_CMD);
    if (known) foreach (cmd_win[i]) cmd_win[i] = 8'hFF;
  endfunction

  function automatic void take_host_byte(logic [7:0] b);
    if (!card_on) return;
    for (int i = 0; i < 5; i++) cmd_win[i] = cmd_win[i + 1];
    cmd_win[5] = b;
    case (mode_now)
      sdspi_pkg::M_IDLE: decode_window();
      sdspi_pkg::M_WAITFE: begin
        if (b == sdspi_pkg::TOKEN_START) begin
          mode_now = sdspi_pkg::M_WDATA;
          last_byte = 8'hFF;
          recv_ptr = 0;
        end
      end
      sdspi_pkg::M_WDATA: begin
        buf_set(recv_ptr, b);
        recv_ptr = (recv_ptr + 1) & 10'h3FF;
        if (recv_ptr == blen + 2) begin
          buf_set(0, save_block(next_blk) ? 8'h05 : 8'h0D);
          buf_set(1, 8'h01);
          begin_reply(2, sdspi_pkg::M_IDLE);
        end
      end
      sdspi_pkg::M_MULTI: begin
        decode_window();
        if (mode_now == sdspi_pkg::M_MULTI && pend == 0) begin
          buf_set(0, sdspi_pkg::TOKEN_START);
          load_block(next_blk, 1);
          next_blk = next_blk + 1;
          append_crc16(1, blen);
          begin_reply(blen + 3, sdspi_pkg::M_MULTI);
        end
      end
      default: if ((cmd_win[0] & 8'h70) == 8'h40 || pend == 0) decode_window();
    endcase
  endfunction

  function automatic logic [7:0] give_card_byte();
    if (!card_on) return 8'hFF;
    if (send_ptr < 1) send_ptr++;
    else if (pend > 0) begin
      last_byte = buf_at(send_ptr - 1);
      send_ptr = (send_ptr + 1) & 10'h3FF;
      pend--;
    end else last_byte = 8'hFF;
    return last_byte;
  endfunction

  // Sends one item and updates the card model at the edge where it is taken.
  task automatic send_item(bit k, logic [7:0] b);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    host_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (!k) take_host_byte(b);
    else card_bytes_due.push_back(give_card_byte());
  endtask

  task automatic read_bytes(int n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_cmd(logic [5:0] op, logic [31:0] arg, bit ended = 1'b1);
    send_item(1'b0, {2'b01, op});
    for (int i = 3; i >= 0; i--) send_item(1'b0, arg[8*i +: 8]);
    send_item(1'b0, {7'($urandom), ended});
  endtask

  // Lets every expected byte arrive, then gives the block time to finish internal work.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (card_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == sdspi_pkg::CFG_CARD_PRESENT) card_on = v;
    else byte_addr = v;
    cfg_we <= 1'b0;
  endtask

  // A full 512-byte read writes every buffer entry that a later reply can show.
  task automatic test_fill_buffer();
    send_cmd(sdspi_pkg::CMD_READ_ONE, 32'd0);
    read_bytes(1 + sdspi_pkg::MAX_BLOCK + 5);
  endtask

  task automatic test_simple_commands();
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0);    read_bytes(3);
    send_cmd(sdspi_pkg::CMD_IF_COND, 32'h1AA);  read_bytes(7);
    send_cmd(sdspi_pkg::CMD_APP_CMD, 32'd0);    read_bytes(2);
    send_cmd(sdspi_pkg::CMD_APP_OP, 32'd0);     read_bytes(2);
    send_cmd(sdspi_pkg::CMD_APP_OP, 32'd0);     read_bytes(2);
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0);    read_bytes(2);
    send_cmd(sdspi_pkg::CMD_SEND_OP, 32'd0);    read_bytes(2);
    send_cmd(sdspi_pkg::CMD_SEND_CSD, 32'd0);   read_bytes(2);
    send_cmd(sdspi_pkg::CMD_SEND_CID, 32'd0);   read_bytes(23);
    send_cmd(sdspi_pkg::CMD_STOP, 32'd0);       read_bytes(2);
    send_cmd(sdspi_pkg::CMD_STATUS, 32'd0);     read_bytes(2);
    send_cmd(sdspi_pkg::CMD_READ_OCR, 32'd0);   read_bytes(7);
    send_cmd(sdspi_pkg::CMD_CRC_ON, 32'd0);     read_bytes(2);
    // An unknown command gives no reply and keeps the window.
    send_cmd(6'd5, 32'hFFFFFFFF);    read_bytes(3);
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0, 1'b0); read_bytes(2);
  endtask

  task automatic test_block_length();
    send_cmd(sdspi_pkg::CMD_SET_BLEN, 32'd0);      read_bytes(2);
    send_cmd(sdspi_pkg::CMD_SET_BLEN, 32'hFFFF);   read_bytes(2);
    send_cmd(sdspi_pkg::CMD_SET_BLEN, 32'd16);     read_bytes(2);
  endtask

  task automatic test_write_read();
    send_cmd(sdspi_pkg::CMD_WRITE_ONE, 32'd2);  read_bytes(2);
    send_item(1'b0, 8'h00);
    send_item(1'b0, sdspi_pkg::TOKEN_START);
    for (int i = 0; i < 18; i++) send_item(1'b0, (i & 1) ? 8'hFF : 8'h00);
    read_bytes(4);
    send_cmd(sdspi_pkg::CMD_READ_ONE, 32'd2);   read_bytes(24);
    // Beyond the end of the store.
    send_cmd(sdspi_pkg::CMD_WRITE_ONE, 32'hFFFFFFFF); read_bytes(2);
    send_item(1'b0, sdspi_pkg::TOKEN_START);
    repeat (18) send_item(1'b0, 8'($urandom));
    read_bytes(4);
    send_cmd(sdspi_pkg::CMD_READ_ONE, 32'h00FFFFFF); read_bytes(24);
  endtask

  task automatic test_multi_read();
    send_cmd(sdspi_pkg::CMD_READ_MULTI, 32'd1); read_bytes(3);
    repeat (3) begin
      send_item(1'b0, 8'hFF);
      read_bytes(21);
    end
    send_cmd(sdspi_pkg::CMD_STOP, 32'd0); read_bytes(25);
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0); read_bytes(2);
  endtask

  task automatic test_config();
    drain();
    write_cfg(sdspi_pkg::CFG_BYTE_ADDRESSING, 1'b1);
    send_cmd(sdspi_pkg::CMD_READ_OCR, 32'd0);   read_bytes(6);
    send_cmd(sdspi_pkg::CMD_READ_ONE, 32'd37);  read_bytes(23);
    drain();
    write_cfg(sdspi_pkg::CFG_CARD_PRESENT, 1'b0);
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0);    read_bytes(4);
    drain();
    write_cfg(sdspi_pkg::CFG_CARD_PRESENT, 1'b1);
    write_cfg(sdspi_pkg::CFG_BYTE_ADDRESSING, 1'b0);
    send_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0);    read_bytes(2);
  endtask

  // The receiver holds off while reads keep coming, so the block backs up.
  task automatic test_backpressure();
    send_cmd(sdspi_pkg::CMD_SEND_CID, 32'd0);
    hold_until = cycle + 400;
    read_bytes(40);
    drain();
  endtask

  function automatic logic [31:0] pick_arg(logic [5:0] op);
    logic [31:0] blk;
    if (op == sdspi_pkg::CMD_SET_BLEN) begin
      case ($urandom_range(19))
        0: return 32'd0;
        1: return sdspi_pkg::MAX_BLOCK;
        2: return $urandom;
        default: return $urandom_range(1, 24);
      endcase
    end
    if (op == sdspi_pkg::CMD_READ_ONE || op == sdspi_pkg::CMD_READ_MULTI ||
        op == sdspi_pkg::CMD_WRITE_ONE) begin
      blk = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 40);
      return byte_addr ? blk * blen + $urandom_range(0, blen - 1) : blk;
    end
    return $urandom;
  endfunction

  task automatic test_random();
    logic [5:0] ops [16];
    logic [5:0] op;
    int         target, next_cfg;
    ops = '{sdspi_pkg::CMD_GO_IDLE, sdspi_pkg::CMD_SEND_OP, sdspi_pkg::CMD_IF_COND,
            sdspi_pkg::CMD_SEND_CSD, sdspi_pkg::CMD_SEND_CID, sdspi_pkg::CMD_STOP,
            sdspi_pkg::CMD_STATUS, sdspi_pkg::CMD_SET_BLEN, sdspi_pkg::CMD_READ_ONE,
            sdspi_pkg::CMD_READ_MULTI, sdspi_pkg::CMD_WRITE_ONE, sdspi_pkg::CMD_APP_OP,
            sdspi_pkg::CMD_APP_CMD, sdspi_pkg::CMD_READ_OCR, sdspi_pkg::CMD_CRC_ON, 6'd0};
    target = ITEMS;
    next_cfg = sent_items + 300;
    while (sent_items < target) begin
      calm = (sent_items % 400) > 300;
      if (sent_items > next_cfg && mode_now != sdspi_pkg::M_WDATA &&
          mode_now != sdspi_pkg::M_WAITFE) begin
        drain();
        write_cfg(sdspi_pkg::CFG_BYTE_ADDRESSING, 1'($urandom_range(1)));
        write_cfg(sdspi_pkg::CFG_CARD_PRESENT, $urandom_range(4) != 0);
        next_cfg = sent_items + 300;
      end
      case (mode_now)
        sdspi_pkg::M_WAITFE:
          send_item(1'b0, ($urandom_range(99) < 85) ? sdspi_pkg::TOKEN_START : 8'($urandom));
        sdspi_pkg::M_WDATA: send_item(1'b0, 8'($urandom));
        sdspi_pkg::M_MULTI: begin
          if ($urandom_range(4) == 0) send_cmd(sdspi_pkg::CMD_STOP, $urandom);
          else send_item(1'b0, 8'($urandom));
          read_bytes($urandom_range(0, blen + 4));
        end
        default: begin
          case ($urandom_range(9))
            0, 1: read_bytes($urandom_range(1, 4));
            2: send_item(1'b0, 8'($urandom));
            default: begin
              op = ops[$urandom_range(15)];
              if (op == 6'd0 && $urandom_range(1)) op = 6'($urandom);
              send_cmd(op, pick_arg(op), $urandom_range(9) != 0);
              read_bytes($urandom_range(0, 24));
            end
          endcase
        end
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_fill_buffer();
    test_simple_commands();
    test_block_length();
    test_write_read();
    test_multi_read();
    test_config();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (card_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (cycle < hold_until) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (card_bytes_due.size() == 0) begin
        $error("card_byte expected none got %h", card_byte);
        errors++;
      end else begin
        logic [7:0] want;
        want = card_bytes_due.pop_front();
        if (card_byte !== want) begin
          $error("card_byte expected %h got %h", want, card_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
